@@ rtl/pla_pkg.sv @@
package pla_pkg;

    // Largest list the count registers are sized for.
    localparam int CAP_MAX     = 64;
    localparam int CNT_W       = $clog2(CAP_MAX + 1);
    localparam int MAX_RESULTS = 16;
    localparam int VAL_W       = 32;

    localparam logic [2:0] REQ_APPEND = 3'd0;
    localparam logic [2:0] REQ_INSERT = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_SEARCH = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;
    localparam logic [2:0] REQ_STATUS = 3'd5;

    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_FULL     = 3'd1;
    localparam logic [2:0] RC_EMPTY    = 3'd2;
    localparam logic [2:0] RC_BADPOS   = 3'd3;
    localparam logic [2:0] RC_NOTFOUND = 3'd4;

    typedef struct packed {
        logic [2:0]              req_type;
        logic [4:0]              position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [2:0]              result_code;
        logic [3:0]              found_index;
        logic signed [VAL_W-1:0] entry_value;
        logic [4:0]              entry_count;
        logic                    is_full;
        logic                    is_empty;
        logic                    last;
    } rsp_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_ROTATE,
        CELL_SEARCH
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [CNT_W-1:0]        pos;
        logic [CNT_W-1:0]        cnt;
        logic signed [VAL_W-1:0] key;
    } cell_cmd_t;

endpackage

@@ rtl/pla_req_if.sv @@
interface pla_req_if;
    logic          valid;
    logic          ready;
    pla_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pla_rsp_if.sv @@
interface pla_rsp_if;
    logic          valid;
    logic          ready;
    pla_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/pla_cell.sv @@
module pla_cell #(
    parameter int IDX = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pla_pkg::cell_cmd_t               cmd,
    input  logic signed [pla_pkg::VAL_W-1:0] left_data,
    input  logic signed [pla_pkg::VAL_W-1:0] right_data,
    input  logic signed [pla_pkg::VAL_W-1:0] head_data,
    output logic signed [pla_pkg::VAL_W-1:0] data,
    output logic                             match
);

    localparam logic [pla_pkg::CNT_W-1:0] MY_IDX  = pla_pkg::CNT_W'(IDX);
    localparam logic [pla_pkg::CNT_W-1:0] MY_NEXT = pla_pkg::CNT_W'(IDX + 1);

    logic signed [pla_pkg::VAL_W-1:0] data_reg;
    logic signed [pla_pkg::VAL_W-1:0] data_next;
    logic                             match_reg;
    logic                             match_next;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (cmd.op)
            pla_pkg::CELL_INSERT:
            begin
                if (MY_IDX > cmd.pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == cmd.pos)
                begin
                    data_next = cmd.key;
                end
            end
            pla_pkg::CELL_REMOVE:
            begin
                if (MY_IDX >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            pla_pkg::CELL_ROTATE:
            begin
                // The last live entry wraps around to take the head.
                if (MY_NEXT == cmd.cnt)
                begin
                    data_next = head_data;
                end
                else
                begin
                    data_next = right_data;
                end
            end
            pla_pkg::CELL_SEARCH:
            begin
                match_next = (data_reg == cmd.key) && (MY_IDX < cmd.cnt);
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

@@ rtl/pla_chain.sv @@
module pla_chain #(
    parameter int CAPACITY = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pla_pkg::cell_cmd_t               cmd,
    output logic signed [pla_pkg::VAL_W-1:0] head,
    output logic                             found,
    output logic [pla_pkg::CNT_W-1:0]        first_idx
);

    logic signed [pla_pkg::VAL_W-1:0] data_w [CAPACITY];
    logic [CAPACITY-1:0]              match_w;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [pla_pkg::VAL_W-1:0] left_d;
        logic signed [pla_pkg::VAL_W-1:0] right_d;

        if (g == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = data_w[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = data_w[g+1];
        end

        pla_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_data  (left_d),
            .right_data (right_d),
            .head_data  (data_w[0]),
            .data       (data_w[g]),
            .match      (match_w[g])
        );
    end

    // Lowest matching cell wins.
    always_comb
    begin
        first_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match_w[i])
            begin
                first_idx = pla_pkg::CNT_W'(i);
            end
        end
    end

    assign found = |match_w;
    assign head  = data_w[0];

endmodule

@@ rtl/positional_array_list_top.sv @@
// Channel | Dir | Handshake     | Payload
// req     | in  | valid / ready | req_type, position, value
// rsp     | out | valid / ready | result_code, found_index, entry_value, entry_count,
//         |     |               | is_full, is_empty, last
//
// Append, insert, remove and status shift the cells, where they do, in the accept cycle,
// and the result is in the output register after the edge that ends it. Search: every
// cell registers its compare, then the first match is encoded once the output is free.
// Read out is the accept cycle, then one rotation per entry.
// Reset clears the count and the control state; stored values are undefined until
// written. A stalled output holds the row, except for rotations past the limit.
module positional_array_list_top #(
    parameter int CAPACITY = 16
) (
    input logic        clk,
    input logic        rst_n,
    pla_req_if.sink    req,
    pla_rsp_if.source  rsp
);

    localparam logic [pla_pkg::CNT_W-1:0] CAP_CNT = pla_pkg::CNT_W'(CAPACITY);
    localparam logic [pla_pkg::CNT_W-1:0] RD_MAX  = pla_pkg::CNT_W'(pla_pkg::MAX_RESULTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_READ
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [pla_pkg::CNT_W-1:0]   count_reg;
    logic [pla_pkg::CNT_W-1:0]   count_next;
    logic [pla_pkg::CNT_W-1:0]   rd_idx_reg;
    logic [pla_pkg::CNT_W-1:0]   rd_idx_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    pla_pkg::rsp_t               out_reg;
    pla_pkg::rsp_t               out_next;

    pla_pkg::cell_cmd_t          cmd;
    logic signed [pla_pkg::VAL_W-1:0] head;
    logic                        found;
    logic [pla_pkg::CNT_W-1:0]   first_idx;

    logic                        out_free;
    logic                        accept;
    logic [pla_pkg::CNT_W-1:0]   pos_ext;
    logic [pla_pkg::CNT_W-1:0]   rd_len;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;
    assign pos_ext   = pla_pkg::CNT_W'(req.data.position);
    assign rd_len    = (count_reg > RD_MAX) ? RD_MAX : count_reg;

    function automatic pla_pkg::rsp_t make_rsp(
        input logic [2:0]                       code,
        input logic [pla_pkg::CNT_W-1:0]        idx,
        input logic signed [pla_pkg::VAL_W-1:0] val,
        input logic [pla_pkg::CNT_W-1:0]        cnt,
        input logic                             fin
    );
        pla_pkg::rsp_t r;
        r.result_code = code;
        r.found_index = idx[3:0];
        r.entry_value = val;
        r.entry_count = cnt[4:0];
        r.is_full     = (cnt == CAP_CNT);
        r.is_empty    = (cnt == '0);
        r.last        = fin;
        return r;
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        cmd.op         = pla_pkg::CELL_HOLD;
        cmd.pos        = pos_ext;
        cmd.cnt        = count_reg;
        cmd.key        = req.data.value;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.data.req_type)
                        pla_pkg::REQ_APPEND:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg >= CAP_CNT)
                            begin
                                out_next = make_rsp(pla_pkg::RC_FULL, '0, '0, count_reg, 1'b1);
                            end
                            else
                            begin
                                cmd.op     = pla_pkg::CELL_INSERT;
                                cmd.pos    = count_reg;
                                count_next = count_reg + 1'b1;
                                out_next   = make_rsp(pla_pkg::RC_OK, '0, '0, count_next, 1'b1);
                            end
                        end
                        pla_pkg::REQ_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg >= CAP_CNT)
                            begin
                                out_next = make_rsp(pla_pkg::RC_FULL, '0, '0, count_reg, 1'b1);
                            end
                            else if (pos_ext > count_reg)
                            begin
                                out_next = make_rsp(pla_pkg::RC_BADPOS, '0, '0, count_reg, 1'b1);
                            end
                            else
                            begin
                                cmd.op     = pla_pkg::CELL_INSERT;
                                count_next = count_reg + 1'b1;
                                out_next   = make_rsp(pla_pkg::RC_OK, '0, '0, count_next, 1'b1);
                            end
                        end
                        pla_pkg::REQ_REMOVE:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                out_next = make_rsp(pla_pkg::RC_EMPTY, '0, '0, count_reg, 1'b1);
                            end
                            else if (pos_ext >= count_reg)
                            begin
                                out_next = make_rsp(pla_pkg::RC_BADPOS, '0, '0, count_reg, 1'b1);
                            end
                            else
                            begin
                                cmd.op     = pla_pkg::CELL_REMOVE;
                                count_next = count_reg - 1'b1;
                                out_next   = make_rsp(pla_pkg::RC_OK, '0, '0, count_next, 1'b1);
                            end
                        end
                        pla_pkg::REQ_SEARCH:
                        begin
                            cmd.op     = pla_pkg::CELL_SEARCH;
                            state_next = S_SEARCH;
                        end
                        pla_pkg::REQ_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                out_next = make_rsp(pla_pkg::RC_EMPTY, '0, '0, count_reg, 1'b1);
                            end
                            else
                            begin
                                rd_idx_next = '0;
                                state_next  = S_READ;
                            end
                        end
                        pla_pkg::REQ_STATUS:
                        begin
                            out_valid_next = 1'b1;
                            out_next = make_rsp(pla_pkg::RC_OK, '0, '0, count_reg, 1'b1);
                        end
                        default:
                        begin
                            // Unknown request types are dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (found)
                    begin
                        out_next = make_rsp(pla_pkg::RC_OK, first_idx, '0, count_reg, 1'b1);
                    end
                    else
                    begin
                        out_next = make_rsp(pla_pkg::RC_NOTFOUND, '0, '0, count_reg, 1'b1);
                    end
                end
            end
            S_READ:
            begin
                // Entries past the result limit still rotate so the row ends in order.
                if ((rd_idx_reg >= RD_MAX) || out_free)
                begin
                    cmd.op      = pla_pkg::CELL_ROTATE;
                    rd_idx_next = rd_idx_reg + 1'b1;
                    if (rd_idx_reg < RD_MAX)
                    begin
                        out_valid_next = 1'b1;
                        out_next = make_rsp(pla_pkg::RC_OK, rd_idx_reg, head, count_reg,
                                            rd_idx_next == rd_len);
                    end
                    if (rd_idx_next == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    pla_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .head      (head),
        .found     (found),
        .first_idx (first_idx)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

`ifndef SYNTH
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_read_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (count_reg != '0) && (rd_idx_reg < count_reg))
        else $error("read out running past the live entries");

    a_search_next : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.data.req_type == pla_pkg::REQ_SEARCH)) |=> (state_reg == S_SEARCH))
        else $error("search did not enter the compare cycle");

    a_count_stable : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(count_reg))
        else $error("entry count changed outside an edit");
`endif

endmodule

@@ verif/positional_array_list_top_tb.sv @@
module positional_array_list_top_tb;

    localparam int LIST_CAP       = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 20;

    // Request codes the block has no meaning for; it must drop them silently.
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    // Keeps a copy of the list and the results each accepted request must produce.
    class list_scoreboard;
        logic signed [pla_pkg::VAL_W-1:0] entries [LIST_CAP];
        int                               fill;
        pla_pkg::rsp_t                    pending_results [$];
        int                               failures;
        int                               results_checked;
        int                               type_hits [8];
        int                               code_hits [5];
        int                               peak_fill;

        function new();
            fill = 0;
            failures = 0;
            results_checked = 0;
            peak_fill = 0;
            foreach (type_hits[i]) type_hits[i] = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
        endfunction

        function void push_result(logic [2:0] code, int idx,
                                  logic signed [pla_pkg::VAL_W-1:0] val, bit is_last);
            pla_pkg::rsp_t r;
            r.result_code = code;
            r.found_index = idx[3:0];
            r.entry_value = val;
            r.entry_count = fill[4:0];
            r.is_full     = (fill == LIST_CAP);
            r.is_empty    = (fill == 0);
            r.last        = is_last;
            pending_results.push_back(r);
            code_hits[code]++;
        endfunction

        function void note_request(pla_pkg::req_t r);
            int  pos;
            int  hit;
            pos = int'(r.position);
            hit = -1;
            type_hits[r.req_type]++;
            case (r.req_type)
                pla_pkg::REQ_APPEND:
                    if (fill >= LIST_CAP) push_result(pla_pkg::RC_FULL, 0, '0, 1'b1);
                    else
                    begin
                        entries[fill] = r.value;
                        fill++;
                        push_result(pla_pkg::RC_OK, 0, '0, 1'b1);
                    end
                pla_pkg::REQ_INSERT:
                    if (fill >= LIST_CAP) push_result(pla_pkg::RC_FULL, 0, '0, 1'b1);
                    else if (pos > fill) push_result(pla_pkg::RC_BADPOS, 0, '0, 1'b1);
                    else
                    begin
                        for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
                        entries[pos] = r.value;
                        fill++;
                        push_result(pla_pkg::RC_OK, 0, '0, 1'b1);
                    end
                pla_pkg::REQ_REMOVE:
                    if (fill == 0) push_result(pla_pkg::RC_EMPTY, 0, '0, 1'b1);
                    else if (pos >= fill) push_result(pla_pkg::RC_BADPOS, 0, '0, 1'b1);
                    else
                    begin
                        for (int i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
                        fill--;
                        push_result(pla_pkg::RC_OK, 0, '0, 1'b1);
                    end
                pla_pkg::REQ_SEARCH:
                begin
                    for (int i = 0; i < fill; i++)
                        if (hit < 0 && entries[i] == r.value) hit = i;
                    if (hit >= 0) push_result(pla_pkg::RC_OK, hit, '0, 1'b1);
                    else push_result(pla_pkg::RC_NOTFOUND, 0, '0, 1'b1);
                end
                pla_pkg::REQ_READ:
                    if (fill == 0) push_result(pla_pkg::RC_EMPTY, 0, '0, 1'b1);
                    else
                        for (int i = 0; i < fill && i < pla_pkg::MAX_RESULTS; i++)
                            push_result(pla_pkg::RC_OK, i, entries[i],
                                        (i + 1 == fill) || (i + 1 == pla_pkg::MAX_RESULTS));
                pla_pkg::REQ_STATUS:
                    push_result(pla_pkg::RC_OK, 0, '0, 1'b1);
                default:
                    ;
            endcase
            if (fill > peak_fill) peak_fill = fill;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(pla_pkg::rsp_t got);
            pla_pkg::rsp_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: code %0d count %0d",
                       got.result_code, got.entry_count);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            compare_field("result_code", want.result_code, got.result_code);
            compare_field("found_index", want.found_index, got.found_index);
            compare_field("entry_value", want.entry_value, got.entry_value);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("is_full", want.is_full, got.is_full);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    pla_req_if req_ch ();
    pla_rsp_if rsp_ch ();

    positional_array_list_top #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    list_scoreboard sb;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             quiet_cycles;
    bit             growing;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Any accepted item on either side counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("positional_array_list_top test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_req(input pla_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    task automatic send_fields(input logic [2:0] kind, input int pos,
                               input logic signed [pla_pkg::VAL_W-1:0] val);
        pla_pkg::req_t r;
        r.req_type = kind;
        r.position = pos[4:0];
        r.value = val;
        send_req(r);
    endtask

    // Holds the request side idle until every outstanding result is back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
    endtask

    function automatic logic signed [pla_pkg::VAL_W-1:0] pick_value();
        logic signed [pla_pkg::VAL_W-1:0] v;
        case ($urandom_range(9))
            0: v = 32'sh8000_0000;
            1: v = 32'sh7fff_ffff;
            2: v = '0;
            3: v = -1;
            4, 5: v = (sb.fill > 0) ? sb.entries[$urandom_range(sb.fill - 1, 0)] : $urandom();
            6: v = $urandom_range(7);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Walks the list between empty and full so both ends see plenty of traffic.
    function automatic pla_pkg::req_t pick_request();
        pla_pkg::req_t r;
        int            n;
        int            roll;
        int            grow_w;
        int            shrink_w;
        n = sb.fill;
        if (n >= LIST_CAP) growing = 1'b0;
        if (n == 0) growing = 1'b1;
        grow_w = growing ? 50 : 16;
        shrink_w = growing ? 12 : 44;
        roll = $urandom_range(99);
        r.value = pick_value();
        r.position = 5'($urandom_range(31));
        if (roll < 3)
            r.req_type = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
        else if (roll < 3 + grow_w)
        begin
            r.req_type = $urandom_range(1) ? pla_pkg::REQ_INSERT : pla_pkg::REQ_APPEND;
            if ($urandom_range(9) < 8) r.position = 5'($urandom_range(n, 0));
        end
        else if (roll < 3 + grow_w + shrink_w)
        begin
            r.req_type = pla_pkg::REQ_REMOVE;
            if (n > 0 && $urandom_range(9) < 8) r.position = 5'($urandom_range(n - 1, 0));
        end
        else if (roll < 88)
            r.req_type = pla_pkg::REQ_SEARCH;
        else if (roll < 95)
            r.req_type = pla_pkg::REQ_READ;
        else
            r.req_type = pla_pkg::REQ_STATUS;
        return r;
    endfunction

    task automatic run_random(input int n_items, input int idle_pct, input int stall_pct);
        pla_pkg::req_t r;
        int            sent;
        sent = 0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items)
        begin
            r = pick_request();
            send_req(r);
            if (r.req_type <= pla_pkg::REQ_STATUS) sent++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        growing = 1'b1;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 38;
        recv_stall_pct = 82;

        // Refusals and misses on an empty list.
        send_fields(pla_pkg::REQ_STATUS, 0, 0);
        send_fields(pla_pkg::REQ_SEARCH, 0, 32'sh7fff_ffff);
        send_fields(pla_pkg::REQ_READ, 0, 0);
        send_fields(pla_pkg::REQ_REMOVE, 31, 0);
        send_fields(pla_pkg::REQ_INSERT, 1, 5);
        send_fields(REQ_UNUSED_LO, 0, 1);

        // Extremes, inserts at front, middle and end, and a duplicate key.
        send_fields(pla_pkg::REQ_INSERT, 0, 32'sh8000_0000);
        send_fields(pla_pkg::REQ_APPEND, 0, 32'sh7fff_ffff);
        send_fields(pla_pkg::REQ_INSERT, 1, -1);
        send_fields(pla_pkg::REQ_INSERT, 3, -1);
        send_fields(pla_pkg::REQ_SEARCH, 0, -1);
        send_fields(pla_pkg::REQ_SEARCH, 0, 12345);
        send_fields(pla_pkg::REQ_REMOVE, 4, 0);
        send_fields(pla_pkg::REQ_REMOVE, 0, 0);
        send_fields(pla_pkg::REQ_READ, 0, 0);
        send_fields(REQ_UNUSED_HI, 31, -1);

        while (sb.fill < LIST_CAP)
            send_fields((sb.fill % 2) ? pla_pkg::REQ_INSERT : pla_pkg::REQ_APPEND,
                        $urandom_range(sb.fill, 0), $urandom());

        // Full wins over a bad position on insert.
        send_fields(pla_pkg::REQ_APPEND, 0, 1);
        send_fields(pla_pkg::REQ_INSERT, 31, 1);
        send_fields(pla_pkg::REQ_READ, 0, 0);
        send_fields(pla_pkg::REQ_SEARCH, 0, sb.entries[LIST_CAP-1]);
        drain();

        run_random(110, 38, 82);
        drain();
        run_random(110, 82, 38);
        drain();
        run_random(110, 0, 0);
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d append, %0d insert, %0d remove, %0d search, %0d read, %0d status",
                 sb.type_hits[pla_pkg::REQ_APPEND], sb.type_hits[pla_pkg::REQ_INSERT],
                 sb.type_hits[pla_pkg::REQ_REMOVE], sb.type_hits[pla_pkg::REQ_SEARCH],
                 sb.type_hits[pla_pkg::REQ_READ], sb.type_hits[pla_pkg::REQ_STATUS]);
        $display("Checked %0d results: %0d full, %0d empty, %0d bad position, %0d miss; peak %0d",
                 sb.results_checked, sb.code_hits[pla_pkg::RC_FULL],
                 sb.code_hits[pla_pkg::RC_EMPTY], sb.code_hits[pla_pkg::RC_BADPOS],
                 sb.code_hits[pla_pkg::RC_NOTFOUND], sb.peak_fill);
        if (sb.failures == 0 && sb.pending_results.size() == 0)
            $display("positional_array_list_top test passed");
        else
            $display("positional_array_list_top test failed");
        $finish;
    end

endmodule
